// File: rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared coordinate width, payload structs and controller/datapath links.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_BITS = 6;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_line_in;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last_pixel;
    } t_pixel_out;

    typedef struct packed {
        logic load;     // capture endpoints
        logic setup;    // order endpoints, compute spans
        logic advance;  // emit one pixel, step the error term
    } t_lr_cmd;

    typedef struct packed {
        logic last;     // current pixel is the far endpoint
    } t_lr_status;

endpackage

// File: rtl/line_rasterizer.sv
// The first pixel is offered after setup and the first run step register it.
// Throughput: one pixel per cycle from the pixel step register while the
// output is not held off; a line of major span D yields D + 1 pixels.
// One line is worked at a time; the last pixel may still wait at the output
// while the next line is accepted.
// Reset: synchronous, active low; clears controller state and output valid.
// ----------------------------------------------------------------------------
// Line rasterizer top level
// Bresenham line generator: endpoints in, one pixel transaction per point.
// ----------------------------------------------------------------------------
module line_rasterizer
    import lr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_line_in   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_pixel_out o_out_data
);

    t_lr_cmd    cmd;
    t_lr_status status;

    lr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    lr_datapath u_datapath (
        .i_clk    (i_clk),
        .i_line   (i_in_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_pixel  (o_out_data)
    );

`ifndef ASSERT_OFF
    a_no_accept_while_drawing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.advance |-> !o_in_ready
    ) else $error("input accepted while a line is being drawn");

    a_load_then_setup: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.setup
    ) else $error("setup did not follow endpoint load");

    a_last_frees_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (cmd.advance && status.last) |=> o_in_ready
    ) else $error("input not ready after the final pixel");

    a_pixel_marks_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (cmd.advance && status.last) |=> (o_out_valid && o_out_data.last_pixel)
    ) else $error("final pixel not flagged at the output");
`endif

endmodule

// File: rtl/lr_ctrl.sv
// ----------------------------------------------------------------------------
// Line rasterizer controller
// Sequences load, setup and per-pixel steps; owns the output valid flag.
// ----------------------------------------------------------------------------
module lr_ctrl
    import lr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_lr_status i_status,
    output t_lr_cmd    o_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   advance;

    // Output slot is free when empty or being drained this cycle
    assign advance    = (r_state == S_RUN) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = o_in_ready && i_in_valid;
        o_cmd.setup   = (r_state == S_SETUP);
        o_cmd.advance = advance;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (advance && i_status.last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/lr_datapath.sv
// ----------------------------------------------------------------------------
// Line rasterizer datapath
// Endpoint registers, span and error arithmetic, pixel output register.
// ----------------------------------------------------------------------------
module lr_datapath
    import lr_pkg::*;
(
    input  logic       i_clk,
    input  t_line_in   i_line,
    input  t_lr_cmd    i_cmd,
    output t_lr_status o_status,
    output t_pixel_out o_pixel
);

    localparam int ErrBits = COORD_BITS + 1;

    t_coord r_ax, r_ay, r_bx, r_by;
    logic   r_steep;

    t_coord r_minor, r_major, r_maj_end, r_dmaj, r_dmin;
    logic   r_step_up;
    logic signed [ErrBits-1:0] r_err;

    t_pixel_out r_pixel;

    t_coord dx, dy;
    t_coord a_maj, a_min, b_maj, b_min;
    t_coord maj0, min0, maj1, min1;
    logic   swap;
    logic signed [ErrBits-1:0] err_sub;

    // Steepness from the raw endpoints
    always_comb begin
        dx = (i_line.end_x >= i_line.start_x) ? i_line.end_x - i_line.start_x
                                              : i_line.start_x - i_line.end_x;
        dy = (i_line.end_y >= i_line.start_y) ? i_line.end_y - i_line.start_y
                                              : i_line.start_y - i_line.end_y;
    end

    // Exchange axes when steep, then order by the major axis
    always_comb begin
        a_maj = r_steep ? r_ay : r_ax;
        a_min = r_steep ? r_ax : r_ay;
        b_maj = r_steep ? r_by : r_bx;
        b_min = r_steep ? r_bx : r_by;
        swap  = (a_maj > b_maj);
        maj0  = swap ? b_maj : a_maj;
        min0  = swap ? b_min : a_min;
        maj1  = swap ? a_maj : b_maj;
        min1  = swap ? a_min : b_min;
    end

    assign err_sub = r_err - $signed({1'b0, r_dmin});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax    <= i_line.start_x;
            r_ay    <= i_line.start_y;
            r_bx    <= i_line.end_x;
            r_by    <= i_line.end_y;
            r_steep <= (dy > dx);
        end

        if (i_cmd.setup) begin
            r_major   <= maj0;
            r_minor   <= min0;
            r_maj_end <= maj1;
            r_dmaj    <= maj1 - maj0;
            r_dmin    <= (min1 >= min0) ? min1 - min0 : min0 - min1;
            r_step_up <= (min0 < min1);
            r_err     <= $signed({1'b0, (maj1 - maj0) >> 1});
        end

        if (i_cmd.advance) begin
            r_pixel.pixel_x    <= r_steep ? r_minor : r_major;
            r_pixel.pixel_y    <= r_steep ? r_major : r_minor;
            r_pixel.last_pixel <= (r_major == r_maj_end);
            r_major            <= r_major + t_coord'(1);
            if (err_sub[ErrBits-1]) begin
                // Term went negative: step the minor axis and add back
                r_minor <= r_step_up ? r_minor + t_coord'(1) : r_minor - t_coord'(1);
                r_err   <= err_sub + $signed({1'b0, r_dmaj});
            end else begin
                r_err   <= err_sub;
            end
        end
    end

    always_comb begin
        o_status      = '0;
        o_status.last = (r_major == r_maj_end);
    end

    assign o_pixel = r_pixel;

endmodule

// File: sim/line_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Drives endpoint pairs through the valid/ready input channel, predicts every
// Bresenham pixel of each line and checks the pixel transactions in order,
// under random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module line_rasterizer_tb;
    import lr_pkg::*;

    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_LINES    = 90;

    class pixel_scoreboard;
        t_pixel_out  expected_pixels[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Rasterize one accepted line and queue its pixels.
        function void note_line(t_line_in l);
            int ax, ay, bx, by;
            int maj0, min0, maj1, min1, tmp;
            int dmaj, dmin, err, step, minor, k;
            bit steep;
            t_pixel_out px;
            ax = l.start_x;
            ay = l.start_y;
            bx = l.end_x;
            by = l.end_y;
            steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
            if (steep) begin
                maj0 = ay; min0 = ax; maj1 = by; min1 = bx;
            end else begin
                maj0 = ax; min0 = ay; maj1 = bx; min1 = by;
            end
            if (maj0 > maj1) begin
                tmp = maj0; maj0 = maj1; maj1 = tmp;
                tmp = min0; min0 = min1; min1 = tmp;
            end
            dmaj  = maj1 - maj0;
            dmin  = (min1 > min0) ? min1 - min0 : min0 - min1;
            err   = dmaj / 2;
            step  = (min0 < min1) ? 1 : -1;
            minor = min0;
            for (k = 0; k <= dmaj; k++) begin
                px.pixel_x    = t_coord'(steep ? minor : maj0 + k);
                px.pixel_y    = t_coord'(steep ? maj0 + k : minor);
                px.last_pixel = (k == dmaj);
                expected_pixels.push_back(px);
                err -= dmin;
                if (err < 0) begin
                    minor += step;
                    err   += dmaj;
                end
            end
        endfunction

        function void check_pixel(t_pixel_out got);
            t_pixel_out exp_px;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
                         got.pixel_x, got.pixel_y, got.last_pixel);
                mismatches++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (got.pixel_x !== exp_px.pixel_x) begin
                $display("%0t: pixel_x expected %0d actual %0d", $time,
                         exp_px.pixel_x, got.pixel_x);
                mismatches++;
            end
            if (got.pixel_y !== exp_px.pixel_y) begin
                $display("%0t: pixel_y expected %0d actual %0d", $time,
                         exp_px.pixel_y, got.pixel_y);
                mismatches++;
            end
            if (got.last_pixel !== exp_px.last_pixel) begin
                $display("%0t: last_pixel expected %0b actual %0b", $time,
                         exp_px.last_pixel, got.last_pixel);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_line_in   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_pixel_out o_out_data;

    pixel_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    bit              hold_req;
    bit              hold_taken;
    int unsigned     hold_cnt;
    int unsigned     quiet_cycles;

    line_rasterizer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 60;
        hold_req      = 1'b0;
        hold_taken    = 1'b0;
        hold_cnt      = 0;
        quiet_cycles  = 0;
        sb            = new();
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready = 1'b0;
        end else begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_cnt   = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                i_out_ready = 1'b0;
                hold_cnt--;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Check outputs before noting inputs; a new line never yields a pixel
    // on the edge it is accepted.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            sb.check_pixel(o_out_data);
        end
        if (i_in_valid && o_in_ready) begin
            sb.note_line(i_in_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d pixels outstanding", $time, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_line(input t_line_in l);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = l;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_points(input int sx, input int sy, input int ex, input int ey);
        t_line_in l;
        l.start_x = t_coord'(sx);
        l.start_y = t_coord'(sy);
        l.end_x   = t_coord'(ex);
        l.end_y   = t_coord'(ey);
        send_line(l);
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    // Mostly arbitrary lines, with short, axis-aligned, diagonal and corner mixes.
    function automatic t_line_in random_line();
        t_line_in l;
        int mode, sx, sy, ex, ey, span, tmp;
        mode = $urandom_range(99);
        sx = $urandom_range(COORD_MAX);
        sy = $urandom_range(COORD_MAX);
        ex = $urandom_range(COORD_MAX);
        ey = $urandom_range(COORD_MAX);
        if (mode < 55) begin
            // keep fully random endpoints
        end else if (mode < 75) begin
            ex = clamp_coord(sx + $urandom_range(8) - 4);
            ey = clamp_coord(sy + $urandom_range(8) - 4);
        end else if (mode < 82) begin
            ey = sy;
        end else if (mode < 89) begin
            ex = sx;
        end else if (mode < 95) begin
            span = (ex > sx) ? ex - sx : sx - ex;
            sy   = $urandom_range(COORD_MAX - span);
            ey   = sy + span;
            if ($urandom_range(1)) begin
                tmp = sy; sy = ey; ey = tmp;
            end
        end else begin
            sx = $urandom_range(1) ? COORD_MAX : 0;
            sy = $urandom_range(1) ? COORD_MAX : 0;
            ex = $urandom_range(1) ? COORD_MAX : 0;
            ey = $urandom_range(1) ? COORD_MAX : 0;
        end
        l.start_x = t_coord'(sx);
        l.start_y = t_coord'(sy);
        l.end_x   = t_coord'(ex);
        l.end_y   = t_coord'(ey);
        return l;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // single points, axis lines both ways, diagonals, shallow and steep
        send_points(0, 0, 0, 0);
        send_points(63, 63, 63, 63);
        send_points(0, 0, 63, 0);
        send_points(63, 0, 0, 0);
        send_points(0, 0, 0, 63);
        send_points(0, 63, 0, 0);
        send_points(0, 0, 63, 63);
        send_points(63, 63, 0, 0);
        send_points(0, 63, 63, 0);
        send_points(63, 0, 0, 63);
        send_points(0, 0, 63, 1);
        send_points(0, 0, 1, 63);
        send_points(5, 10, 20, 13);
        send_points(20, 13, 5, 10);
        send_points(10, 5, 13, 20);
        send_points(13, 20, 10, 5);
        send_points(0, 0, 2, 1);
        send_points(3, 3, 4, 5);
        send_points(42, 21, 21, 42);
        send_points(1, 2, 2, 1);
        send_points(63, 62, 0, 63);

        repeat (PHASE_LINES) send_line(random_line());

        send_idle_pct = 60;
        recv_idle_pct = 10;
        repeat (PHASE_LINES) send_line(random_line());

        // no idling; stall the output long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (PHASE_LINES) send_line(random_line());

        @(negedge i_clk);
        i_in_valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/lr_pkg.sv
rtl/lr_ctrl.sv
rtl/lr_datapath.sv
rtl/line_rasterizer.sv
sim/line_rasterizer_tb.sv
